/* src/sdehs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdehs_pkg
// Types and constants shared by the servo drive enable and home sequencer.
// ----------------------------------------------------------------------------
package sdehs_pkg;

    // Request modes.
    typedef enum logic [1:0] {
        MODE_ENABLE  = 2'd0,
        MODE_HOME    = 2'd1,
        MODE_FOLLOW  = 2'd2,
        MODE_DISABLE = 2'd3
    } t_mode;

    // Report codes.
    typedef enum logic [2:0] {
        RPT_ENABLING    = 3'd0,
        RPT_ALL_ENABLED = 3'd1,
        RPT_HOMING      = 3'd2,
        RPT_ALL_HOME    = 3'd3,
        RPT_FOLLOWING   = 3'd4,
        RPT_NO_TARGET   = 3'd5,
        RPT_DISABLING   = 3'd6
    } t_report;

    // Drive states in the low byte of the status word.
    localparam logic [7:0] ST_ENABLED     = 8'h37;
    localparam logic [7:0] ST_SWITCHED_ON = 8'h33;
    localparam logic [7:0] ST_READY_A     = 8'h31;
    localparam logic [7:0] ST_READY_B     = 8'h21;
    localparam logic [7:0] ST_SW_DISABLED = 8'h50;

    // Control words.
    localparam logic [3:0] CW_NONE      = 4'h0;
    localparam logic [3:0] CW_SHUTDOWN  = 4'h6;
    localparam logic [3:0] CW_SWITCH_ON = 4'h7;
    localparam logic [3:0] CW_ENABLE_OP = 4'hF;

    localparam int          HOME_WINDOW = 80 * 3;
    localparam int          HOME_STEP   = 120 * 3;
    localparam logic [2:0]  HOLD_TOP    = 3'd5;

    // Configuration registers: one home position per joint.
    localparam int NUM_HOME  = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    typedef struct packed {
        t_mode              req_type;
        logic [2:0]         joint;
        logic               last_joint;
        logic [15:0]        drv_status;
        logic signed [31:0] actual_position;
        logic               target_present;
        logic signed [31:0] stream_target;
    } t_in_word;

    typedef struct packed {
        logic               ctrl_write;
        logic [3:0]         ctl_code;
        logic               pos_write;
        logic signed [31:0] pos_target;
        t_report            report;
        logic               joint_fault;
        logic               all_enabled;
        logic               all_at_default;
    } t_out_word;

    // One joint's entry in the state memory.
    typedef struct packed {
        logic [15:0]        last_status;
        logic [2:0]         hold_count;
        logic               enabled;
        logic               homed;
        logic signed [31:0] cmd_pos;
    } t_entry;

    localparam t_entry ENTRY_RST = '{
        last_status: 16'h0000,
        hold_count:  HOLD_TOP,
        enabled:     1'b0,
        homed:       1'b0,
        cmd_pos:     32'sd0
    };

endpackage

/* src/servo_drive_enable_home_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_drive_enable_home_sequencer
// Per-joint drive enable, homing, target follow and disable sequencer.
// ----------------------------------------------------------------------------
// An accepted word's result is registered into r_out when the compute stage
// (r_s1, r_rd) advances. Throughput: one word per cycle unless the output
// stalls, set by the single read-modify-write of the joint state memory; a
// write to the same joint is forwarded to the next word.
// Reset clears the latched flags, sets the accumulators and marks every joint
// entry as unwritten, so it reads as its reset value until first written.
module servo_drive_enable_home_sequencer
    import sdehs_pkg::*;
#(
    parameter int NUM_JOINTS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_word             i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_word            o_out_word,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int AW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
    localparam logic signed [33:0] P_MAX = 34'sd2147483647;
    localparam logic signed [33:0] P_MIN = -(34'sd2147483648);

    logic signed [31:0] r_home [NUM_HOME];

    t_entry             r_mem [NUM_JOINTS];
    logic [NUM_JOINTS-1:0] r_vld;

    logic      r_s1_vld;
    t_in_word  r_s1;
    t_entry    r_rd;
    logic      r_rd_vld;

    logic      r_wb_vld;
    logic [AW-1:0] r_wb_idx;
    t_entry    r_wb;

    logic      r_out_vld;
    t_out_word r_out;

    logic r_acc_en, r_acc_hm, r_flag_en, r_flag_hm;
    logic n_acc_en, n_acc_hm, n_flag_en, n_flag_hm;

    logic      adv, accept, s1_go, jv;
    logic [AW-1:0] idx0, idx1;
    t_entry    cur, n_entry;
    t_out_word res;

    assign adv        = !r_out_vld || !i_out_stall;
    assign o_in_stall = r_s1_vld && !adv;
    assign accept     = i_in_valid && !o_in_stall;
    assign s1_go      = r_s1_vld && adv;
    assign idx0       = i_in_word.joint[AW-1:0];
    assign idx1       = r_s1.joint[AW-1:0];
    assign jv         = 32'(r_s1.joint) < NUM_JOINTS;

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_HOME; i++) begin
                r_home[i] <= 32'sd0;
            end
        end else if (i_cfg_we) begin
            r_home[i_cfg_idx] <= i_cfg_data;
        end
    end

    // Joint state memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (s1_go && jv) begin
            r_mem[idx1] <= n_entry;
        end
        if (accept) begin
            r_rd <= r_mem[idx0];
        end
    end

    // Control state: valid bits, pipeline, forwarding record, flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_rd_vld  <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_wb_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_acc_en  <= 1'b1;
            r_acc_hm  <= 1'b1;
            r_flag_en <= 1'b0;
            r_flag_hm <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_vld <= 1'b1;
                r_rd_vld <= r_vld[idx0];
            end else if (adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_go) begin
                r_out_vld <= 1'b1;
                r_acc_en  <= n_acc_en;
                r_acc_hm  <= n_acc_hm;
                r_flag_en <= n_flag_en;
                r_flag_hm <= n_flag_hm;
                if (jv) begin
                    r_vld[idx1] <= 1'b1;
                    r_wb_vld    <= 1'b1;
                end
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= i_in_word;
        end
        if (s1_go) begin
            r_out <= res;
            if (jv) begin
                r_wb_idx <= idx1;
                r_wb     <= n_entry;
            end
        end
    end

    // The last write is forwarded, since the memory read of this word may have
    // happened at the same edge as that write.
    always_comb begin
        if (r_wb_vld && (r_wb_idx == idx1)) begin
            cur = r_wb;
        end else if (r_rd_vld) begin
            cur = r_rd;
        end else begin
            cur = ENTRY_RST;
        end
    end

    always_comb begin
        logic [7:0]         low;
        logic signed [33:0] act, home, cmd, cmd_dn, cmd_up;
        logic               en, hm;

        low     = r_s1.drv_status[7:0];
        act     = 34'(r_s1.actual_position);
        home    = 34'(r_home[r_s1.joint]);
        cmd     = 34'(cur.cmd_pos);
        cmd_dn  = cmd - 34'(HOME_STEP);
        cmd_up  = cmd + 34'(HOME_STEP);
        en      = 1'b0;
        hm      = 1'b0;
        n_entry = cur;
        n_acc_en  = r_acc_en;
        n_acc_hm  = r_acc_hm;
        n_flag_en = r_flag_en;
        n_flag_hm = r_flag_hm;
        res.ctrl_write  = 1'b0;
        res.ctl_code    = CW_NONE;
        res.pos_write   = 1'b0;
        res.report      = RPT_ENABLING;
        res.joint_fault = 1'b0;

        case (r_s1.req_type)
            MODE_ENABLE: begin
                if (r_flag_en) begin
                    res.report = RPT_ALL_ENABLED;
                end else begin
                    if (jv) begin
                        if (cur.last_status != r_s1.drv_status) begin
                            n_entry.last_status = r_s1.drv_status;
                            n_entry.hold_count  = HOLD_TOP;
                        end
                        if (low != ST_ENABLED) begin
                            n_entry.enabled = 1'b0;
                            if (n_entry.hold_count == HOLD_TOP) begin
                                if (low == ST_SW_DISABLED) begin
                                    res.ctrl_write = 1'b1;
                                    res.ctl_code   = CW_SHUTDOWN;
                                end else if (low == ST_READY_A || low == ST_READY_B) begin
                                    n_entry.cmd_pos = r_s1.actual_position;
                                    res.pos_write   = 1'b1;
                                    res.ctrl_write  = 1'b1;
                                    res.ctl_code    = CW_SWITCH_ON;
                                end else if (low == ST_SWITCHED_ON) begin
                                    n_entry.cmd_pos = r_s1.actual_position;
                                    res.pos_write   = 1'b1;
                                    res.ctrl_write  = 1'b1;
                                    res.ctl_code    = CW_ENABLE_OP;
                                end
                            end
                            if (n_entry.hold_count == 3'd0 || n_entry.hold_count > HOLD_TOP) begin
                                n_entry.hold_count = HOLD_TOP;
                            end else begin
                                n_entry.hold_count = n_entry.hold_count - 3'd1;
                            end
                        end else begin
                            n_entry.enabled = 1'b1;
                        end
                        en = n_entry.enabled;
                    end
                    n_acc_en = r_acc_en && en;
                    if (r_s1.last_joint) begin
                        n_flag_en = n_acc_en;
                        n_acc_en  = 1'b1;
                    end
                end
            end
            MODE_HOME: begin
                if (r_flag_hm) begin
                    res.report = RPT_ALL_HOME;
                end else begin
                    res.report = RPT_HOMING;
                    if (jv) begin
                        if (low == ST_ENABLED) begin
                            if (!cur.homed) begin
                                if (act > home + 34'(HOME_WINDOW)) begin
                                    n_entry.cmd_pos = (cmd_dn < P_MIN) ? P_MIN[31:0]
                                                                       : cmd_dn[31:0];
                                end else if (act < home - 34'(HOME_WINDOW)) begin
                                    n_entry.cmd_pos = (cmd_up > P_MAX) ? P_MAX[31:0]
                                                                       : cmd_up[31:0];
                                end else begin
                                    n_entry.homed = 1'b1;
                                end
                                res.pos_write = 1'b1;
                            end
                        end else begin
                            res.joint_fault = 1'b1;
                        end
                        hm = n_entry.homed;
                    end
                    n_acc_hm = r_acc_hm && hm;
                    if (r_s1.last_joint) begin
                        n_flag_hm = n_acc_hm;
                        n_acc_hm  = 1'b1;
                    end
                end
            end
            MODE_FOLLOW: begin
                if (!r_s1.target_present) begin
                    res.report = RPT_NO_TARGET;
                end else begin
                    res.report = RPT_FOLLOWING;
                    if (jv) begin
                        if (low == ST_ENABLED) begin
                            n_entry.cmd_pos = r_s1.stream_target;
                            res.pos_write   = 1'b1;
                        end else begin
                            res.joint_fault = 1'b1;
                        end
                    end
                end
            end
            default: begin
                res.report = RPT_DISABLING;
                if (jv) begin
                    if (cur.last_status != r_s1.drv_status) begin
                        n_entry.last_status = r_s1.drv_status;
                        n_entry.hold_count  = HOLD_TOP;
                    end
                    if (low == ST_ENABLED) begin
                        res.ctrl_write = 1'b1;
                        res.ctl_code   = CW_SWITCH_ON;
                    end else if (low == ST_SWITCHED_ON || low == ST_READY_B) begin
                        res.ctrl_write = 1'b1;
                        res.ctl_code   = CW_SHUTDOWN;
                    end
                end
            end
        endcase

        res.pos_target     = jv ? n_entry.cmd_pos : 32'sd0;
        res.all_enabled    = n_flag_en;
        res.all_at_default = n_flag_hm;
    end

    // The input side stalls only behind a word held in the compute stage.
    a_stall_needs_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_vld)
        else $error("input stalled with an empty compute stage");

    // A latched report must agree with the flag shown beside it.
    a_rpt_all_en: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.report == RPT_ALL_ENABLED) |-> o_out_word.all_enabled)
        else $error("all-enabled report without the flag");

    a_rpt_all_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.report == RPT_ALL_HOME) |-> o_out_word.all_at_default)
        else $error("all-home report without the flag");

    // The hold counter never leaves its range once written back.
    a_hold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && jv) |-> (n_entry.hold_count <= HOLD_TOP))
        else $error("hold counter out of range");

    // Faults come only from homing or following.
    a_fault_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.joint_fault) |->
            (o_out_word.report == RPT_HOMING || o_out_word.report == RPT_FOLLOWING))
        else $error("joint fault outside homing or following");

endmodule
